// ===== hw/rtl/dbmb_pkg.sv =====
// ----------------------------------------------------------------------------
// dbmb_pkg
// Shared types and codes of the dual-bank message buffer: request and
// response beats, operation and status codes, bank states and defaults.
// ----------------------------------------------------------------------------
package dbmb_pkg;

	localparam int CHANNELS_DEF   = 2;
	localparam int BANK_DEPTH_DEF = 32;
	localparam int MSG_WIDTH_DEF  = 64;

	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_RD_FULL = 2'd1;
	localparam logic [1:0] OP_RD_FILL = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	typedef enum logic [1:0] {
		B_EMPTY   = 2'd0,
		B_FILLING = 2'd1,
		B_FULL    = 2'd2
	} bank_state_t;

	typedef enum logic {
		S_IDLE,
		S_STREAM
	} fsm_state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  channel;
		logic [63:0] msg_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] msg_out;
		logic        msg_valid;
		logic [6:0]  batch_count;
		logic        is_last;
	} rsp_t;

endpackage

// ===== hw/rtl/dual_bank_message_buffer.sv =====
// ----------------------------------------------------------------------------
// dual_bank_message_buffer
// Ping-pong buffer of received messages, two banks per channel, held in one
// synchronous message memory with per-channel bank state in flip-flops.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload | Beats
//  req     | req_valid/req_stall  | req_t   | one per request
//  rsp     | rsp_valid/rsp_stall  | rsp_t   | one per write, 1..BANK_DEPTH per read
//
// A write or a single-beat answer is one response beat; a read batch of n
// messages is n beats, one memory read each, during which requests are stalled.
// The memory's single read port sets the one message per cycle streaming rate
// if unstalled. A stall holds the memory read data; the stream resumes on release.
// Reset puts bank 0 of every channel in the filling state and bank 1 empty.
// ----------------------------------------------------------------------------
module dual_bank_message_buffer #(
	parameter int CHANNELS   = dbmb_pkg::CHANNELS_DEF,
	parameter int BANK_DEPTH = dbmb_pkg::BANK_DEPTH_DEF,
	parameter int MSG_WIDTH  = dbmb_pkg::MSG_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dbmb_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dbmb_pkg::rsp_t rsp
);
	import dbmb_pkg::*;

	localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW        = $clog2(BANK_DEPTH + 1);
	localparam int MEM_DEPTH = 2 * CHANNELS * BANK_DEPTH;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(BANK_DEPTH);

	typedef struct packed {
		bank_state_t [1:0]        st;
		logic        [1:0][CW-1:0] cnt;
	} chan_t;

	chan_t                chan_q [CHANNELS];
	logic [MSG_WIDTH-1:0] mem    [MEM_DEPTH];
	logic [MSG_WIDTH-1:0] rdata_q;

	fsm_state_t state_q, next_state;

	logic          rsp_valid_q;
	logic [1:0]    rsp_status_q;
	logic          rsp_mvalid_q;
	logic [CW-1:0] rsp_count_q;
	logic          rsp_last_q;

	logic [CHW:0]  bank_q;
	logic [CW-1:0] k_q;
	logic [CW-1:0] n_q;

	logic          advance, accept, ch_ok;
	logic [CHW-1:0] ch_idx;
	chan_t         cur, nxt;
	logic          upd, wr_en, strm_go, sel, found, ovf;
	logic          wb, sj;
	logic [CW-1:0] wk, strm_n;
	logic [1:0]    res_status;
	logic          stream_last;
	logic          rd_en;
	logic [CHW:0]  rd_bank;
	logic [CW-1:0] rd_k;
	logic [AW-1:0] rd_addr, wr_addr;

	assign advance = !rsp_valid_q || !rsp_stall;
	assign accept  = req_valid && !req_stall;
	assign ch_idx  = req.channel[CHW-1:0];
	assign ch_ok   = ({1'b0, req.channel} < 5'(CHANNELS));
	assign cur     = chan_q[ch_idx];
	assign stream_last = ((k_q + CW'(1)) == n_q);

	// Request decode: bank state update, message write and batch selection.
	always_comb begin
		nxt        = cur;
		upd        = 1'b0;
		wr_en      = 1'b0;
		wb         = 1'b0;
		wk         = '0;
		strm_go    = 1'b0;
		strm_n     = '0;
		sj         = 1'b0;
		sel        = 1'b0;
		found      = 1'b0;
		ovf        = 1'b0;
		res_status = ST_ERR;
		if (ch_ok) begin
			case (req.op)
				OP_WRITE: begin
					if (cur.st[0] == B_FILLING) begin
						sel = 1'b0;
						found = 1'b1;
					end else if (cur.st[1] == B_FILLING) begin
						sel = 1'b1;
						found = 1'b1;
					end else if (cur.st[0] == B_EMPTY && cur.st[1] == B_EMPTY) begin
						sel = 1'b0;
						found = 1'b1;
						nxt.st[0] = B_FILLING;
					end
					if (found) begin
						upd = 1'b1;
						ovf = (cur.cnt[sel] >= DEPTH_C);
						if (ovf) begin
							nxt.st[sel] = B_FULL;
							// Switching into a bank that is still full drops the message.
							if (cur.st[~sel] != B_FULL) begin
								nxt.st[~sel] = B_FILLING;
								wb = ~sel;
								wk = (cur.cnt[~sel] >= DEPTH_C) ? '0 : cur.cnt[~sel];
								nxt.cnt[~sel] = wk + CW'(1);
								wr_en = 1'b1;
								res_status = ST_OK;
							end
						end else begin
							wb = sel;
							wk = cur.cnt[sel];
							nxt.cnt[sel] = wk + CW'(1);
							wr_en = 1'b1;
							res_status = ST_OK;
						end
					end
				end
				OP_RD_FULL: begin
					if (cur.st[0] == B_FULL) begin
						sj = 1'b0;
						found = 1'b1;
					end else if (cur.st[1] == B_FULL) begin
						sj = 1'b1;
						found = 1'b1;
					end
					if (found) begin
						upd = 1'b1;
						nxt.st[sj] = B_EMPTY;
						nxt.cnt[sj] = '0;
						res_status = ST_OK;
						strm_n = DEPTH_C;
						strm_go = 1'b1;
					end else begin
						res_status = ST_NONE;
					end
				end
				OP_RD_FILL: begin
					if (cur.st[0] == B_FILLING) begin
						sj = 1'b0;
						found = 1'b1;
					end else if (cur.st[1] == B_FILLING) begin
						sj = 1'b1;
						found = 1'b1;
					end
					if (found) begin
						upd = 1'b1;
						nxt.st[sj] = B_EMPTY;
						nxt.cnt[sj] = '0;
						res_status = ST_OK;
						strm_n = cur.cnt[sj];
						strm_go = (cur.cnt[sj] != '0);
					end
				end
				default: begin
					res_status = ST_ERR;
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		next_state = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && strm_go && strm_n > CW'(1)) begin
					next_state = S_STREAM;
				end
			end
			S_STREAM: begin
				if (advance && stream_last) begin
					next_state = S_IDLE;
				end
			end
			default: begin
				next_state = S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: request stall and memory read control.
	always_comb begin
		req_stall = 1'b1;
		rd_en     = 1'b0;
		rd_bank   = {ch_idx, sj};
		rd_k      = '0;
		case (state_q)
			S_IDLE: begin
				req_stall = !advance;
				rd_en     = accept && strm_go;
			end
			S_STREAM: begin
				rd_bank = bank_q;
				rd_k    = k_q;
				rd_en   = advance;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	assign rd_addr = AW'(rd_bank) * AW'(BANK_DEPTH) + AW'(rd_k);
	assign wr_addr = AW'({ch_idx, wb}) * AW'(BANK_DEPTH) + AW'(wk);

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			mem[wr_addr] <= req.msg_in[MSG_WIDTH-1:0];
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				chan_q[c].st[0]  <= B_FILLING;
				chan_q[c].st[1]  <= B_EMPTY;
				chan_q[c].cnt[0] <= '0;
				chan_q[c].cnt[1] <= '0;
			end
		end else begin
			state_q <= next_state;
			if (accept && upd) begin
				chan_q[ch_idx] <= nxt;
			end
			if (accept || (state_q == S_STREAM && advance)) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response fields and stream position; the message itself is rdata_q.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			bank_q <= {ch_idx, sj};
			k_q    <= CW'(1);
			n_q    <= strm_n;
			if (strm_go) begin
				rsp_status_q <= ST_OK;
				rsp_mvalid_q <= 1'b1;
				rsp_count_q  <= strm_n;
				rsp_last_q   <= (strm_n == CW'(1));
			end else begin
				rsp_status_q <= res_status;
				rsp_mvalid_q <= 1'b0;
				rsp_count_q  <= '0;
				rsp_last_q   <= 1'b1;
			end
		end else if (state_q == S_STREAM && advance) begin
			k_q        <= k_q + CW'(1);
			rsp_last_q <= stream_last;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.msg_out     = rsp_mvalid_q ? 64'(rdata_q) : 64'd0;
	assign rsp.msg_valid   = rsp_mvalid_q;
	assign rsp.batch_count = 7'(rsp_count_q);
	assign rsp.is_last     = rsp_last_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual-bank message buffer testbench
// Drives request beats in random bursts while the response side stalls on a
// pattern of its own. A scoreboard keeps its own copy of the bank states,
// fill counts and stored messages and checks every response beat in order.
// ----------------------------------------------------------------------------
module testbench;
	import dbmb_pkg::*;

	localparam int CH       = CHANNELS_DEF;
	localparam int DEPTH    = BANK_DEPTH_DEF;
	localparam int MSG_W    = MSG_WIDTH_DEF;
	localparam int N_ITEMS  = 370;
	localparam int IDLE_MAX = 5000;
	localparam int DRAIN    = 20;
	localparam logic [1:0] OP_BAD = 2'd3;

	class msg_buffer_scoreboard;
		bank_state_t bank_st[2*CH];
		int unsigned fill[2*CH];
		logic [63:0] store[2*CH*DEPTH];
		rsp_t        expected_q[$];
		int          mismatches;

		function new();
			for (int c = 0; c < CH; c++) begin
				bank_st[2*c]   = B_FILLING;
				bank_st[2*c+1] = B_EMPTY;
				fill[2*c]      = 0;
				fill[2*c+1]    = 0;
			end
			mismatches = 0;
		endfunction

		function void post(logic [1:0] st, logic [63:0] m, logic v, int cnt, logic last);
			rsp_t e;
			e.status      = st;
			e.msg_out     = m;
			e.msg_valid   = v;
			e.batch_count = cnt[6:0];
			e.is_last     = last;
			expected_q.push_back(e);
		endfunction

		function int find_bank(int ch, bank_state_t want);
			if (bank_st[2*ch] == want)
				return 0;
			if (bank_st[2*ch+1] == want)
				return 1;
			return -1;
		endfunction

		function void stream_bank(int b, int n);
			if (n > DEPTH)
				n = DEPTH;
			if (n == 0) begin
				post(ST_OK, '0, 1'b0, 0, 1'b1);
			end else begin
				for (int k = 0; k < n; k++)
					post(ST_OK, store[b*DEPTH+k], 1'b1, n, (k + 1 == n));
			end
			bank_st[b] = B_EMPTY;
			fill[b]    = 0;
		endfunction

		function logic [1:0] write_msg(int ch, logic [63:0] m);
			int j;
			int b;
			int other;
			j = find_bank(ch, B_FILLING);
			if (j < 0) begin
				if (bank_st[2*ch] == B_EMPTY && bank_st[2*ch+1] == B_EMPTY) begin
					j = 0;
					bank_st[2*ch] = B_FILLING;
				end else begin
					return ST_ERR;
				end
			end
			b = 2*ch + j;
			// An overflowing bank hands over to its partner unless that one is
			// still waiting to be read, in which case the message is lost.
			if (fill[b] >= DEPTH) begin
				other = 2*ch + (j ^ 1);
				bank_st[b] = B_FULL;
				if (bank_st[other] == B_FULL)
					return ST_ERR;
				bank_st[other] = B_FILLING;
				b = other;
				if (fill[b] >= DEPTH)
					fill[b] = 0;
			end
			store[b*DEPTH+fill[b]] = m;
			fill[b]++;
			return ST_OK;
		endfunction

		function void note_request(req_t r);
			int ch;
			int j;
			logic [63:0] m;
			ch = int'(r.channel);
			m  = r.msg_in & ({64{1'b1}} >> (64 - MSG_W));
			if (ch >= CH || r.op == OP_BAD) begin
				post(ST_ERR, '0, 1'b0, 0, 1'b1);
				return;
			end
			case (r.op)
				OP_WRITE: begin
					post(write_msg(ch, m), '0, 1'b0, 0, 1'b1);
				end
				OP_RD_FULL: begin
					j = find_bank(ch, B_FULL);
					if (j < 0)
						post(ST_NONE, '0, 1'b0, 0, 1'b1);
					else
						stream_bank(2*ch + j, DEPTH);
				end
				default: begin
					j = find_bank(ch, B_FILLING);
					if (j < 0)
						post(ST_ERR, '0, 1'b0, 0, 1'b1);
					else
						stream_bank(2*ch + j, fill[2*ch + j]);
				end
			endcase
		endfunction

		function void report(string what, logic [63:0] exp_v, logic [63:0] got_v);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, got_v);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				report("unexpected beat", '0, got.msg_out);
				return;
			end
			e = expected_q.pop_front();
			if (got.status !== e.status)
				report("status", 64'(e.status), 64'(got.status));
			if (got.msg_out !== e.msg_out)
				report("msg_out", e.msg_out, got.msg_out);
			if (got.msg_valid !== e.msg_valid)
				report("msg_valid", 64'(e.msg_valid), 64'(got.msg_valid));
			if (got.batch_count !== e.batch_count)
				report("batch_count", 64'(e.batch_count), 64'(got.batch_count));
			if (got.is_last !== e.is_last)
				report("is_last", 64'(e.is_last), 64'(got.is_last));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	msg_buffer_scoreboard sb = new();
	int idle_cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	int stall_left = 0;
	int stall_pct = 0;

	dual_bank_message_buffer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	// The response side alternates between free-running, light, heavy and
	// near-solid stalling, each phase of random length.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_left <= $urandom_range(32, 200);
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 20;
				2: stall_pct <= 50;
				default: stall_pct <= 85;
			endcase
		end else begin
			stall_left <= stall_left - 1;
		end
		rsp_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		logic req_fire;
		logic rsp_fire;
		req_fire = arst_n && req_valid && (req_stall === 1'b0);
		rsp_fire = arst_n && (rsp_valid === 1'b1) && !rsp_stall;
		if (req_fire)
			sb.note_request(req);
		if (rsp_fire)
			sb.check_response(rsp);
		idle_cycles <= (req_fire || rsp_fire) ? 0 : idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_MAX);
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [63:0] rand_msg();
		return {$urandom, $urandom};
	endfunction

	// Sends one request beat; the sender runs in bursts separated by gaps.
	task automatic issue(logic [1:0] op, int unsigned ch, logic [63:0] m);
		req_t r;
		r.op      = op;
		r.channel = ch[3:0];
		r.msg_in  = m;
		if (burst_left == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
			                                          : $urandom_range(1, 16);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall !== 1'b0);
		burst_left--;
		items_sent++;
	endtask

	// Holds the sender back until every outstanding response beat has come.
	task automatic drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (2) @(posedge clk);
		burst_left = 0;
	endtask

	initial begin
		int unsigned ch;
		int roll;
		int n;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reading the empty filling bank, extreme messages, short
		// batches, reads with nothing to give, bad channels and the unused op.
		issue(OP_RD_FILL, 1, '0);
		issue(OP_RD_FILL, 1, '0);
		issue(OP_WRITE, 1, {64{1'b1}});
		issue(OP_WRITE, 0, {64{1'b1}});
		issue(OP_WRITE, 0, '0);
		issue(OP_WRITE, 0, 64'h5555_5555_5555_5555);
		issue(OP_WRITE, 0, 64'hAAAA_AAAA_AAAA_AAAA);
		issue(OP_RD_FILL, 0, '0);
		issue(OP_RD_FILL, 0, '0);
		issue(OP_RD_FULL, 0, '0);
		issue(OP_WRITE, 0, 64'h8000_0000_0000_0001);
		issue(OP_RD_FULL, 1, '0);
		issue(OP_RD_FILL, 0, '0);
		issue(OP_RD_FILL, 1, '0);
		issue(OP_WRITE, 2, rand_msg());
		issue(OP_RD_FULL, 15, {64{1'b1}});
		issue(OP_RD_FILL, 15, '0);
		issue(OP_BAD, 0, rand_msg());
		issue(OP_BAD, 15, {64{1'b1}});
		drain();

		// Random: mostly write runs with random content, long enough now and
		// then to overflow one bank or both, mixed with reads and some noise.
		while (items_sent < N_ITEMS) begin
			ch   = $urandom_range(0, CH - 1);
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				case ($urandom_range(0, 9))
					0: n = $urandom_range(64, 70);
					1, 2, 3: n = $urandom_range(28, 40);
					default: n = $urandom_range(1, 12);
				endcase
				repeat (n) issue(OP_WRITE, ch, rand_msg());
			end else if (roll < 70) begin
				issue(OP_RD_FULL, ch, rand_msg());
			end else if (roll < 88) begin
				issue(OP_RD_FILL, ch, rand_msg());
			end else if (roll < 94) begin
				issue(OP_BAD, $urandom_range(0, 15), rand_msg());
			end else begin
				issue(2'($urandom_range(0, 2)), $urandom_range(CH, 15), rand_msg());
			end
			if ($urandom_range(0, 19) == 0)
				drain();
		end

		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		repeat (DRAIN) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
